// ===== rtl/core/s3i_pkg.sv =====
// Shared types and constants for the symmetric 3x3 inverse pipeline.
// No dependencies.
`default_nettype none
package s3i_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int AdjW     = 64;
  localparam int DetW     = 98;
  localparam int MagW     = DetW - 1;
  localparam int NumW     = AdjW + 2 * FracBits;
  localparam int QuoW     = 32;
  localparam int ThrW     = 63;
  localparam int Lanes    = 6;
  localparam logic [ThrW-1:0] ThrReset = 63'd28147;

  typedef struct packed {
    logic signed [DataW-1:0] m_xx;
    logic signed [DataW-1:0] m_xy;
    logic signed [DataW-1:0] m_xz;
    logic signed [DataW-1:0] m_yy;
    logic signed [DataW-1:0] m_yz;
    logic signed [DataW-1:0] m_zz;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] inv_xx;
    logic signed [DataW-1:0] inv_xy;
    logic signed [DataW-1:0] inv_xz;
    logic signed [DataW-1:0] inv_yy;
    logic signed [DataW-1:0] inv_yz;
    logic signed [DataW-1:0] inv_zz;
    logic                    singular;
    logic                    saturated;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/core/symmetric_3x3_inverse.sv =====
// Symmetric 3x3 matrix inverse by adjugate over determinant, Q16.16, fully pipelined.
// Depends on s3i_pkg.
`default_nettype none
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------
//  input     | in_valid_i / in_ready_o      | in_data_i   (in_t)
//  output    | out_valid_o / out_ready_i    | out_data_o  (out_t)
//  config    | det_threshold_we_i           | det_threshold_i (63 bit)
//
// One beat enters per cycle while the pipe is not held. The pipe has two adjugate
// stages, three determinant stages, one classify stage, 32 restoring-divide stages (one
// quotient bit per stage, six lanes side by side), one rounding stage and the
// saturating output register. Reset clears the valid chain and loads the
// threshold. When the output register holds an untaken beat the whole pipe
// holds; nothing is dropped or repeated.
module symmetric_3x3_inverse
  import s3i_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire in_t             in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output out_t                 out_data_o,
  input  wire logic            det_threshold_we_i,
  input  wire logic [ThrW-1:0] det_threshold_i
);

  localparam int DivSt = QuoW;

  logic            en;
  logic [ThrW-1:0] thr_q;

  // advance everything whenever the output slot is free or being taken
  logic out_valid_q;
  assign en          = ~out_valid_q | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (det_threshold_we_i) begin
      thr_q <= det_threshold_i;
    end
  end

  // ---------------- stage 1: twelve 32x32 products ----------------
  logic                   v1_q;
  logic signed [AdjW-1:0] p_q [12];
  logic signed [DataW-1:0] a1_q, b1_q, c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]  <= in_data_i.m_yy * in_data_i.m_zz;
      p_q[1]  <= in_data_i.m_yz * in_data_i.m_yz;
      p_q[2]  <= in_data_i.m_xz * in_data_i.m_yz;
      p_q[3]  <= in_data_i.m_xy * in_data_i.m_zz;
      p_q[4]  <= in_data_i.m_xy * in_data_i.m_yz;
      p_q[5]  <= in_data_i.m_xz * in_data_i.m_yy;
      p_q[6]  <= in_data_i.m_xx * in_data_i.m_zz;
      p_q[7]  <= in_data_i.m_xz * in_data_i.m_xz;
      p_q[8]  <= in_data_i.m_xy * in_data_i.m_xz;
      p_q[9]  <= in_data_i.m_xx * in_data_i.m_yz;
      p_q[10] <= in_data_i.m_xx * in_data_i.m_yy;
      p_q[11] <= in_data_i.m_xy * in_data_i.m_xy;
      a1_q    <= in_data_i.m_xx;
      b1_q    <= in_data_i.m_xy;
      c1_q    <= in_data_i.m_xz;
    end
  end

  // ---------------- stage 2: adjugate entries ----------------
  logic                    v2_q;
  logic signed [AdjW-1:0]  adj2_q [Lanes];
  logic signed [DataW-1:0] a2_q, b2_q, c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < Lanes; k++) begin
        adj2_q[k] <= p_q[2*k] - p_q[2*k+1];
      end
      a2_q <= a1_q;
      b2_q <= b1_q;
      c2_q <= c1_q;
    end
  end

  // ---------------- stage 3: split 32x64 into two partial products ----------------
  logic                        v3_q;
  logic signed [DataW+32:0]    pl_q  [3];
  logic signed [AdjW-1:0]      ph_q  [3];
  logic signed [AdjW-1:0]      adj3_q [Lanes];
  logic signed [DataW-1:0]     coef  [3];

  assign coef[0] = a2_q;
  assign coef[1] = b2_q;
  assign coef[2] = c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int t = 0; t < 3; t++) begin
        pl_q[t] <= coef[t] * $signed({1'b0, adj2_q[t][31:0]});
        ph_q[t] <= coef[t] * $signed(adj2_q[t][AdjW-1:32]);
      end
      adj3_q <= adj2_q;
    end
  end

  // ---------------- stage 4: recombine each term ----------------
  logic                   v4_q;
  logic signed [DetW-1:0] term_q [3];
  logic signed [AdjW-1:0] adj4_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int t = 0; t < 3; t++) begin
        term_q[t] <= DetW'($signed({ph_q[t], 32'd0})) + DetW'(pl_q[t]);
      end
      adj4_q <= adj3_q;
    end
  end

  // ---------------- stage 5: determinant ----------------
  logic                   v5_q;
  logic signed [DetW-1:0] det5_q;
  logic signed [AdjW-1:0] adj5_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det5_q <= term_q[0] + term_q[1] + term_q[2];
      adj5_q <= adj4_q;
    end
  end

  // ---------------- stage 6: classify, set up dividers ----------------
  // divider chain index 0 is the classify output, DivSt the last quotient bit
  logic             dv_q    [DivSt+1];
  logic             dsing_q [DivSt+1];
  logic [MagW-1:0]  ddet_q  [DivSt+1];
  logic [Lanes-1:0] dneg_q  [DivSt+1];
  logic [Lanes-1:0] dovf_q  [DivSt+1];
  logic [MagW-1:0]  r_q     [DivSt+1][Lanes];
  logic [QuoW-1:0]  q_q     [DivSt+1][Lanes];
  logic [QuoW-1:0]  nlo_q   [DivSt+1][Lanes];

  logic            sing6;
  logic [AdjW-1:0] mag6  [Lanes];
  logic [NumW-1:0] num6  [Lanes];
  logic [MagW-1:0] rin6  [Lanes];

  // negative, zero, or under the floor: singular
  assign sing6 = det5_q[DetW-1] || (det5_q == '0) ||
                 (det5_q[DetW-2:0] < MagW'(thr_q));

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      mag6[k] = adj5_q[k][AdjW-1] ? AdjW'(-adj5_q[k]) : AdjW'(adj5_q[k]);
      num6[k] = NumW'(mag6[k]) << (2 * FracBits);
      rin6[k] = MagW'(num6[k][NumW-1:QuoW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (en) dv_q[0] <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsing_q[0] <= sing6;
      ddet_q[0]  <= det5_q[DetW-2:0];
      for (int k = 0; k < Lanes; k++) begin
        dneg_q[0][k] <= adj5_q[k][AdjW-1];
        // quotient would need more than 32 bits
        dovf_q[0][k] <= rin6[k] >= det5_q[DetW-2:0];
        r_q[0][k]    <= rin6[k];
        q_q[0][k]    <= '0;
        nlo_q[0][k]  <= num6[k][QuoW-1:0];
      end
    end
  end

  // ---------------- divide stages: one quotient bit each ----------------
  for (genvar j = 0; j < DivSt; j++) begin : g_div
    logic [MagW:0]   r2  [Lanes];
    logic            ge  [Lanes];
    logic [MagW-1:0] rn  [Lanes];

    always_comb begin
      for (int k = 0; k < Lanes; k++) begin
        r2[k] = {r_q[j][k], nlo_q[j][k][QuoW-1]};
        ge[k] = r2[k] >= {1'b0, ddet_q[j]};
        rn[k] = ge[k] ? MagW'(r2[k] - {1'b0, ddet_q[j]}) : r2[k][MagW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else if (en) dv_q[j+1] <= dv_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dsing_q[j+1] <= dsing_q[j];
        ddet_q[j+1]  <= ddet_q[j];
        dneg_q[j+1]  <= dneg_q[j];
        dovf_q[j+1]  <= dovf_q[j];
        for (int k = 0; k < Lanes; k++) begin
          r_q[j+1][k]   <= rn[k];
          q_q[j+1][k]   <= {q_q[j][k][QuoW-2:0], ge[k]};
          nlo_q[j+1][k] <= {nlo_q[j][k][QuoW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- round half away from zero ----------------
  logic             vr_q;
  logic             rsing_q;
  logic [Lanes-1:0] rneg_q, rovf_q;
  logic [QuoW:0]    q1_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vr_q <= 1'b0;
    else if (en) vr_q <= dv_q[DivSt];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsing_q <= dsing_q[DivSt];
      rneg_q  <= dneg_q[DivSt];
      rovf_q  <= dovf_q[DivSt];
      for (int k = 0; k < Lanes; k++) begin
        q1_q[k] <= {1'b0, q_q[DivSt][k]} +
                   (QuoW+1)'({r_q[DivSt][k], 1'b0} >= {1'b0, ddet_q[DivSt]});
      end
    end
  end

  // ---------------- saturate, sign, output register ----------------
  logic [DataW-1:0] val  [Lanes];
  logic [Lanes-1:0] clip;
  logic [QuoW:0]    lim  [Lanes];
  out_t             out_q;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      lim[k]  = rneg_q[k] ? {1'b0, 1'b1, 31'd0} : {2'b00, {31{1'b1}}};
      clip[k] = !rsing_q && (rovf_q[k] || (q1_q[k] > lim[k]));
      if (rsing_q) begin
        val[k] = '0;
      end else if (clip[k]) begin
        val[k] = lim[k][DataW-1:0];
        if (rneg_q[k]) val[k] = {1'b1, 31'd0};
      end else if (rneg_q[k]) begin
        val[k] = DataW'(-q1_q[k][DataW-1:0]);
      end else begin
        val[k] = q1_q[k][DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vr_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.inv_xx    <= val[0];
      out_q.inv_xy    <= val[1];
      out_q.inv_xz    <= val[2];
      out_q.inv_yy    <= val[3];
      out_q.inv_yz    <= val[4];
      out_q.inv_zz    <= val[5];
      out_q.singular  <= rsing_q;
      out_q.saturated <= |clip;
    end
  end

  assign out_data_o = out_q;

  // ---------------- assertions ----------------
  // a singular beat carries a zero matrix and no clip flag
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.inv_xx == '0 && out_data_o.inv_xy == '0 && out_data_o.inv_xz == '0 &&
      out_data_o.inv_yy == '0 && out_data_o.inv_yz == '0 && out_data_o.inv_zz == '0 &&
      !out_data_o.saturated)
    else $error("singular beat with nonzero payload");

  // a held pipe keeps every in-flight beat where it is
  a_hold_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(v5_q) && $stable(dv_q[DivSt]) && $stable(vr_q))
    else $error("pipeline moved while held");

  // a beat in the first divide stage moves on to the second whenever the pipe advances
  a_div_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && dv_q[1] |=> dv_q[2])
    else $error("beat lost inside divider");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for symmetric_3x3_inverse: streams symmetric matrices, predicts each
// inverse with wide integer arithmetic and compares every output beat field by field.
// Depends on s3i_pkg and the symmetric_3x3_inverse RTL.
module testbench;
  import s3i_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 40;
  localparam longint CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic det_threshold_we_i = 1'b0;
  logic [ThrW-1:0] det_threshold_i = '0;

  // sender and receiver idle percentages; changed between test phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  logic [ThrW-1:0] threshold_model;
  out_t expected_inverses[$];
  int unsigned error_count = 0;
  longint cycle_count = 0;

  always #10 clk_i = ~clk_i;

  symmetric_3x3_inverse u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_data_i          (in_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_data_o         (out_data_o),
    .det_threshold_we_i (det_threshold_we_i),
    .det_threshold_i    (det_threshold_i)
  );

  // Predict one inverse: exact adjugate and determinant, then a rounded,
  // saturated quotient per entry (ties away from zero).
  function automatic out_t predict_inverse(in_t m);
    out_t r;
    logic signed [63:0] a, b, c, d, e, f;
    logic signed [63:0] adj[6];
    logic signed [127:0] det;
    logic [127:0] num, mag_det, quo, rem, lim;
    logic sing;
    a = 64'(m.m_xx); b = 64'(m.m_xy); c = 64'(m.m_xz);
    d = 64'(m.m_yy); e = 64'(m.m_yz); f = 64'(m.m_zz);
    adj[0] = d * f - e * e;
    adj[1] = c * e - b * f;
    adj[2] = b * e - c * d;
    adj[3] = a * f - c * c;
    adj[4] = b * c - a * e;
    adj[5] = a * d - b * b;
    det = 128'(a) * 128'(adj[0]) + 128'(b) * 128'(adj[1]) + 128'(c) * 128'(adj[2]);
    // negative and zero determinants are always singular
    sing = (det <= 0) || (det < $signed({65'd0, threshold_model}));
    r = '0;
    r.singular = sing;
    if (!sing) begin
      mag_det = det;
      for (int k = 0; k < Lanes; k++) begin
        num = (adj[k] < 0) ? 128'(-adj[k]) : 128'(adj[k]);
        num = num << (2 * FracBits);
        quo = num / mag_det;
        rem = num % mag_det;
        if ((rem << 1) >= mag_det) quo = quo + 1;
        lim = (adj[k] < 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim) begin
          quo = lim;
          r.saturated = 1'b1;
        end
        if (adj[k] < 0) quo = -quo;
        case (k)
          0: r.inv_xx = quo[31:0];
          1: r.inv_xy = quo[31:0];
          2: r.inv_xz = quo[31:0];
          3: r.inv_yy = quo[31:0];
          4: r.inv_yz = quo[31:0];
          default: r.inv_zz = quo[31:0];
        endcase
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Cycle counter and timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall at random, compare each accepted beat with the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_inverses.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_inverses.pop_front();
        if (out_data_o.inv_xx !== want.inv_xx)
          report_mismatch("inv_xx", out_data_o.inv_xx, want.inv_xx);
        if (out_data_o.inv_xy !== want.inv_xy)
          report_mismatch("inv_xy", out_data_o.inv_xy, want.inv_xy);
        if (out_data_o.inv_xz !== want.inv_xz)
          report_mismatch("inv_xz", out_data_o.inv_xz, want.inv_xz);
        if (out_data_o.inv_yy !== want.inv_yy)
          report_mismatch("inv_yy", out_data_o.inv_yy, want.inv_yy);
        if (out_data_o.inv_yz !== want.inv_yz)
          report_mismatch("inv_yz", out_data_o.inv_yz, want.inv_yz);
        if (out_data_o.inv_zz !== want.inv_zz)
          report_mismatch("inv_zz", out_data_o.inv_zz, want.inv_zz);
        if (out_data_o.singular !== want.singular)
          report_mismatch("singular", out_data_o.singular, want.singular);
        if (out_data_o.saturated !== want.saturated)
          report_mismatch("saturated", out_data_o.saturated, want.saturated);
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one beat: optional idle gap, then hold valid until accepted.
  // Valid stays high after the beat is taken; idle cycles or the caller drop it.
  task automatic send_matrix(in_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    do @(posedge clk_i); while (!in_ready_o);
    expected_inverses.push_back(predict_inverse(m));
  endtask

  // Drain: wait for every prediction to be matched, then let the pipe settle.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] value);
    det_threshold_we_i <= 1'b1;
    det_threshold_i    <= value;
    @(posedge clk_i);
    det_threshold_we_i <= 1'b0;
    threshold_model = value;
  endtask

  function automatic in_t make_matrix(logic signed [31:0] xx, xy, xz, yy, yz, zz);
    in_t m;
    m.m_xx = xx; m.m_xy = xy; m.m_xz = xz;
    m.m_yy = yy; m.m_yz = yz; m.m_zz = zz;
    return m;
  endfunction

  // Random value of a chosen scale so small, mid and full-range entries all occur.
  function automatic logic signed [31:0] rand_entry();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(131072)) - 65536);
      1: return 32'($signed($urandom_range(4194304)) - 2097152);
      2: return 32'($signed($urandom_range(256)) - 128);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-conditioned: large positive diagonals with shrunken off-diagonal entries.
  function automatic in_t rand_matrix();
    in_t m;
    logic signed [31:0] s;
    m = make_matrix(rand_entry(), rand_entry(), rand_entry(),
                    rand_entry(), rand_entry(), rand_entry());
    if ($urandom_range(99) < 70) begin
      s = 32'($urandom_range(1 << 20));
      m.m_xy = m.m_xy >>> 12; m.m_xz = m.m_xz >>> 12; m.m_yz = m.m_yz >>> 12;
      m.m_xx = s + 32'($urandom_range(1 << 21)) + 32'h0001_0000;
      m.m_yy = s + 32'($urandom_range(1 << 21)) + 32'h0001_0000;
      m.m_zz = s + 32'($urandom_range(1 << 21)) + 32'h0001_0000;
    end
    return m;
  endfunction

  // Directed: identity, zero, negative determinant, extremes, tiny and huge inverses.
  task automatic test_directed();
    logic signed [31:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    send_matrix(make_matrix(32'h10000, 0, 0, 32'h10000, 0, 32'h10000));
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(-32'sh10000, 0, 0, 32'h10000, 0, 32'h10000));
    send_matrix(make_matrix(mx, 0, 0, mx, 0, mx));
    send_matrix(make_matrix(mn, 0, 0, mn, 0, mn));
    send_matrix(make_matrix(mx, mx, mx, mx, mx, mx));
    send_matrix(make_matrix(mn, mx, mn, mx, mn, mx));
    send_matrix(make_matrix(mx, mn, mn, mx, mn, mx));
    send_matrix(make_matrix(1, 0, 0, 1, 0, 1));
    send_matrix(make_matrix(32'h100, 0, 0, 32'h100, 0, 32'h100));
    send_matrix(make_matrix(32'h20000, 32'h10000, 0, 32'h20000, 32'h10000, 32'h20000));
    send_matrix(make_matrix(32'h10000, 32'h10000, 0, 32'h10000, 0, 32'h10000));
    send_matrix(make_matrix(32'h30000, -32'sh8000, 32'h4000, 32'h30000, -32'sh2000,
                            32'h30000));
    send_matrix(make_matrix(32'h10000, 0, 0, 32'h10000, 0, -32'sh10000));
    send_matrix(make_matrix(-1, -1, -1, -1, -1, -1));
    send_matrix(make_matrix(32'h555, -32'sh2AA, 32'h1, 32'h777, 32'h0, 32'h999));
    drain_pipe();
  endtask

  // Threshold sweep: zero, just around a known determinant, maximum, default.
  task automatic test_threshold();
    in_t ident;
    ident = make_matrix(32'h10000, 0, 0, 32'h10000, 0, 32'h10000);
    // determinant of identity is 2^48
    write_threshold(63'd0);
    send_matrix(ident);
    send_matrix(make_matrix(1, 0, 0, 1, 0, 1));
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0));
    drain_pipe();
    write_threshold(63'h1_0000_0000_0000);
    send_matrix(ident);
    drain_pipe();
    write_threshold(63'h1_0000_0000_0001);
    send_matrix(ident);
    drain_pipe();
    write_threshold(63'h7FFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 10; i++) send_matrix(rand_matrix());
    send_matrix(make_matrix(32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF));
    drain_pipe();
    write_threshold(ThrReset);
  endtask

  // Random stream under one idle setting of sender and receiver.
  task automatic test_random(int unsigned count, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      send_matrix(rand_matrix());
      // hold off once, halfway through, until every prediction is matched
      if (i == count / 2) begin
        in_valid_i <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge clk_i);
      end
    end
    drain_pipe();
  endtask

  initial begin
    threshold_model = ThrReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold();
    test_random(650, 38, 61);
    write_threshold(63'($urandom_range(1 << 30)) << $urandom_range(30));
    test_random(650, 61, 38);
    write_threshold(ThrReset);
    test_random(600, 0, 0);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
